// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the label encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dnle_pkg.sv =====
// Shared types and constants of the DNS name label encoder.
`default_nettype none

package dnle_pkg;

    // Label limits and widths.
    localparam int MAX_LABEL   = 62;
    localparam int LEN_W       = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W      = $clog2(MAX_LABEL);
    localparam int CHAR_W      = 8;
    localparam int BUDGET_W    = 16;
    localparam int APB_ADDR_W  = 2;

    // Input commands.
    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Label separator.
    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'd46;

    // Register addresses.
    localparam logic [APB_ADDR_W-1:0] REG_BYTE_BUDGET = 2'd0;
    localparam logic [BUDGET_W-1:0]   BUDGET_RESET    = 16'd512;

    // Flag positions within the result tuser.
    localparam int USER_W      = 3;
    localparam int USER_IS_LEN = 0;
    localparam int USER_EON    = 1;
    localparam int USER_OVF    = 2;

    // Request from the sequencer to the budget unit.
    typedef struct packed {
        logic add_one;  // compare bytes_used + 1 rather than bytes_used
        logic step;     // commit one byte
        logic restart;  // fresh name: one byte reserved
    } bud_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dnle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dnle_budget.sv =====
// Byte budget unit: holds the committed byte count and its one shared add and compare.
`default_nettype none

module dnle_budget (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [dnle_pkg::BUDGET_W-1:0] byte_budget,
    input  wire dnle_pkg::bud_ctl_t          ctl,
    output logic                             room
);
    import dnle_pkg::*;

    `include "assert_macros.svh"

    logic [BUDGET_W-1:0] bytes_used_reg;
    logic [BUDGET_W-1:0] bytes_used_next;
    logic [BUDGET_W:0]   sum;

    // The one adder and comparator, shared by every budget check.
    assign sum  = {1'b0, bytes_used_reg} + {{BUDGET_W{1'b0}}, ctl.add_one};
    assign room = (sum <= {1'b0, byte_budget});

    // Commit or restart the count.
    always_comb
    begin
        bytes_used_next = bytes_used_reg;
        if (ctl.restart)
        begin
            bytes_used_next = {{(BUDGET_W-1){1'b0}}, 1'b1};
        end
        else if (ctl.step)
        begin
            bytes_used_next = sum[BUDGET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_used_reg <= {{(BUDGET_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            bytes_used_reg <= bytes_used_next;
        end
    end

    // A commit is only requested once the compare has found room.
    `ASSERT_CLK(a_step_needs_room, !ctl.step || ctl.restart || (room && ctl.add_one), "byte committed without room")
    // The reserved length byte is never given back.
    `ASSERT_CLK(a_used_nonzero, bytes_used_reg != '0, "byte count dropped to zero")

endmodule

`default_nettype wire

// ===== hw/rtl/dns_name_label_encoder.sv =====
// Top level of the DNS name label encoder: sequencer, label RAM, budget unit, APB register.
//
//  Channel  | Direction | Handshake                 | Payload
//  s_*      | in        | s_tvalid / s_tready       | s_tdata = name_char, s_tuser = command
//  m_*      | out       | m_tvalid / m_tready       | m_tdata = out_byte, m_tuser = flags, m_tlast
//  APB      | in        | psel, penable, pready = 1 | byte_budget at address 0
//
// An ordinary character is taken in ST_IDLE, then checked and stored in ST_EVAL.
// A dot that closes a label goes on to ST_LEN for the length byte, then to ST_DATA for
// each label byte, with ST_RD between bytes for the registered read data of the label RAM.
// Finish adds ST_TERM for the terminator; ST_OVF sends an overflow result after the check.
// A full output register that is not taken stalls the sequencer; the input is taken only
// when the sequencer is idle. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module dns_name_label_encoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] name_char
    input  wire logic [0:0]                        s_tuser,   // [0] command
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // [7:0] out_byte
    output logic [2:0]                             m_tuser,   // [0] is_length, [1] end_of_name,
                                                              // [2] overflow
    output logic                                   m_tlast,   // last_of_run
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dnle_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import dnle_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_OVF  = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_TERM = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                disc_reg, disc_next;
    logic                fin_reg, fin_next;
    logic                cmd_reg, cmd_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [BUDGET_W-1:0] budget_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_byte_reg, out_byte_next;
    logic [USER_W-1:0]   out_user_reg, out_user_next;
    logic                out_last_reg, out_last_next;

    logic                slot_free;
    logic                last_idx;
    logic                room;
    logic                ram_we;
    logic [CHAR_W-1:0]   ram_rdata;
    bud_ctl_t            bud_ctl;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_BYTE_BUDGET) ? {16'd0, budget_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_BYTE_BUDGET))
        begin
            budget_reg <= pwdata[BUDGET_W-1:0];
        end
    end

    // Label store and budget unit.
    dnle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LABEL)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (char_reg),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    dnle_budget u_budget (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_budget (budget_reg),
        .ctl         (bud_ctl),
        .room        (room)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || m_tready;
    assign last_idx  = (LEN_W'(idx_reg) == (len_reg - {{(LEN_W-1){1'b0}}, 1'b1}));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        disc_next       = disc_reg;
        fin_next        = fin_reg;
        cmd_next        = cmd_reg;
        char_next       = char_reg;
        ram_we          = 1'b0;
        bud_ctl.add_one = !(cmd_reg == CMD_FINISH && len_reg == '0);
        bud_ctl.step    = 1'b0;
        bud_ctl.restart = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser[0];
                    char_next  = s_tdata;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                idx_next = '0;
                if (cmd_reg == CMD_FINISH)
                begin
                    if (disc_reg)
                    begin
                        len_next        = '0;
                        disc_next       = 1'b0;
                        bud_ctl.restart = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else if (!room)
                    begin
                        len_next        = '0;
                        bud_ctl.restart = 1'b1;
                        state_next      = ST_OVF;
                    end
                    else if (len_reg != '0)
                    begin
                        fin_next   = 1'b1;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_TERM;
                    end
                end
                else if (disc_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (char_reg == DOT_CHAR)
                begin
                    if (len_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!room)
                    begin
                        disc_next  = 1'b1;
                        len_next   = '0;
                        state_next = ST_OVF;
                    end
                    else
                    begin
                        bud_ctl.step = 1'b1;
                        fin_next     = 1'b0;
                        state_next   = ST_LEN;
                    end
                end
                else if (len_reg >= LEN_W'(MAX_LABEL) || !room)
                begin
                    disc_next  = 1'b1;
                    len_next   = '0;
                    state_next = ST_OVF;
                end
                else
                begin
                    ram_we       = 1'b1;
                    len_next     = len_reg + {{(LEN_W-1){1'b0}}, 1'b1};
                    bud_ctl.step = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_OVF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_user_next  = USER_W'(1) << USER_OVF;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CHAR_W'(len_reg);
                    out_user_next  = USER_W'(1) << USER_IS_LEN;
                    out_last_next  = 1'b0;
                    state_next     = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_user_next  = '0;
                    out_last_next  = last_idx && !fin_reg;
                    if (last_idx)
                    begin
                        if (fin_reg)
                        begin
                            state_next = ST_TERM;
                        end
                        else
                        begin
                            len_next   = '0;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                // Wait for the registered read of the new address.
                state_next = ST_DATA;
            end
            ST_TERM:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = '0;
                    out_user_next   = USER_W'(1) << USER_EON;
                    out_last_next   = 1'b1;
                    len_next        = '0;
                    disc_next       = 1'b0;
                    bud_ctl.restart = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            disc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        fin_reg      <= fin_next;
        cmd_reg      <= cmd_next;
        char_reg     <= char_next;
        out_byte_reg <= out_byte_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // An accepted request is always checked on the next cycle.
    `ASSERT_NEXT(a_accept_eval, s_tvalid && s_tready, state_reg == ST_EVAL, "request not checked")
    // An overflow result is a lone zero byte that ends its run.
    `ASSERT_CLK(a_ovf_form, !(m_tvalid && m_tuser[USER_OVF]) || (m_tlast && m_tdata == '0), "bad overflow result")
    // While characters are dropped no label is pending.
    `ASSERT_CLK(a_disc_empty, !disc_reg || len_reg == '0, "label pending while discarding")
    // The pending label never exceeds the label limit.
    `ASSERT_CLK(a_len_limit, len_reg <= LEN_W'(MAX_LABEL), "label longer than limit")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the DNS name label encoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnle_pkg::*;

    // One request on the input stream.
    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] ch;
    } name_req_t;

    // One encoded byte as it should leave the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_length;
        logic       end_of_name;
        logic       overflow;
        logic       last_of_run;
    } wire_byte_t;

    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [7:0] name_char
    logic [0:0]            s_tuser = '0;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [7:0] out_byte
    logic [2:0]            m_tuser;        // [0] is_length, [1] end_of_name, [2] overflow
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Stimulus and expectations.
    name_req_t  name_reqs[$];
    wire_byte_t wire_bytes_due[$];
    int         reqs_queued = 0;
    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_toggle = 1'b0;
    logic       hold_seen = 1'b0;
    int         hold_left = 0;

    // Predictor state.
    logic [7:0] pend_label[MAX_LABEL];
    int         pend_len = 0;
    int         used_bytes = 1;
    logic       dropping = 1'b0;
    int         budget_now = BUDGET_RESET;

    dns_name_label_encoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock and the single reset at the start.
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Safety net against a hung block.
    initial
    begin
        #5000000;
        $display("** dns_name_label_encoder: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void start_name();
        pend_len   = 0;
        used_bytes = 1;
        dropping   = 1'b0;
    endfunction

    function automatic void push_byte(logic [7:0] b, logic len_flag, logic eon,
                                      logic ovf, logic last);
        wire_byte_t wb;
        wb.out_byte    = b;
        wb.is_length   = len_flag;
        wb.end_of_name = eon;
        wb.overflow    = ovf;
        wb.last_of_run = last;
        wire_bytes_due.push_back(wb);
    endfunction

    // Length byte followed by the buffered characters; the last one may close the run.
    function automatic void push_label(logic closes_run);
        push_byte(8'(pend_len), 1'b1, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < pend_len; i++)
            push_byte(pend_label[i], 1'b0, 1'b0, 1'b0, closes_run && (i == pend_len - 1));
    endfunction

    function automatic void encode_request(logic cmd, logic [7:0] ch);
        // Finish: flush, terminate, fresh name.
        if (cmd == CMD_FINISH)
        begin
            if (dropping)
            begin
                start_name();
                return;
            end
            if (pend_len != 0)
            begin
                if (used_bytes + 1 > budget_now)
                begin
                    start_name();
                    push_byte(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
                    return;
                end
                push_label(1'b0);
            end
            else if (used_bytes > budget_now)
            begin
                start_name();
                push_byte(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
                return;
            end
            push_byte(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
            start_name();
            return;
        end

        if (dropping)
            return;

        // Separator: empty labels vanish, others are flushed.
        if (ch == DOT_CHAR)
        begin
            if (pend_len == 0)
                return;
            if (used_bytes + 1 > budget_now)
            begin
                dropping = 1'b1;
                pend_len = 0;
                push_byte(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
                return;
            end
            used_bytes++;
            push_label(1'b1);
            pend_len = 0;
            return;
        end

        // Ordinary character: label limit and budget are both checked.
        if (pend_len >= MAX_LABEL || used_bytes + 1 > budget_now)
        begin
            dropping = 1'b1;
            pend_len = 0;
            push_byte(8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
            return;
        end
        pend_label[pend_len] = ch;
        pend_len++;
        used_bytes++;
    endfunction

    // ---------------------------------------------------------------
    // Input driver: takes pending requests, predicts on acceptance
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : request_driver
        name_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                encode_request(s_tuser[0], s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (name_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = name_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.ch;
                    s_tuser  <= req.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started whenever the stimulus flips hold_toggle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_toggle;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: random back-pressure and field-by-field check
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : result_monitor
        wire_byte_t due;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (wire_bytes_due.size() == 0)
                begin
                    $error("unexpected result: out_byte %0d, tuser %b, tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    due = wire_bytes_due.pop_front();
                    if (m_tdata !== due.out_byte)
                    begin
                        $error("out_byte: expected %0d, got %0d", due.out_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[USER_IS_LEN] !== due.is_length)
                    begin
                        $error("is_length: expected %0d, got %0d", due.is_length,
                               m_tuser[USER_IS_LEN]);
                        fail_count++;
                    end
                    if (m_tuser[USER_EON] !== due.end_of_name)
                    begin
                        $error("end_of_name: expected %0d, got %0d", due.end_of_name,
                               m_tuser[USER_EON]);
                        fail_count++;
                    end
                    if (m_tuser[USER_OVF] !== due.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", due.overflow,
                               m_tuser[USER_OVF]);
                        fail_count++;
                    end
                    if (m_tlast !== due.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d", due.last_of_run, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic push_req(logic cmd, logic [7:0] ch);
        name_req_t req;
        req.cmd = cmd;
        req.ch  = ch;
        name_reqs.push_back(req);
        reqs_queued++;
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == DOT_CHAR)
            c = 8'h2d;
        return c;
    endfunction

    // A short well-formed dotted name with random content, now and then with stray dots.
    task automatic queue_name();
        int n_labels;
        int len;
        n_labels = $urandom_range(1, 2);
        if ($urandom_range(7) == 0)
            push_req(CMD_CHAR, DOT_CHAR);
        for (int l = 0; l < n_labels; l++)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                push_req(CMD_CHAR, label_char());
            if (l != n_labels - 1 || $urandom_range(3) == 0)
                push_req(CMD_CHAR, DOT_CHAR);
            if ($urandom_range(9) == 0)
                push_req(CMD_CHAR, DOT_CHAR);
        end
        push_req(CMD_FINISH, 8'($urandom_range(1, 255)));
    endtask

    // Unstructured requests: any byte, many dots, finish at random.
    task automatic queue_noise(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(7) == 0)
                push_req(CMD_FINISH, 8'($urandom_range(255)));
            else if ($urandom_range(3) == 0)
                push_req(CMD_CHAR, DOT_CHAR);
            else
                push_req(CMD_CHAR, 8'($urandom_range(255)));
        end
    endtask

    // Wait until every request has been taken and every result has arrived.
    task automatic wait_drained();
        @(negedge clk);
        while (name_reqs.size() != 0 || s_tvalid || wire_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    // Register write over APB; the block is drained and idle first.
    task automatic write_budget(int value);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BYTE_BUDGET;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        budget_now = value & 16'hFFFF;
        @(negedge clk);
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, int n_reqs,
                                bit long_hold, bit mid_pause);
        int half_mark;
        int stop_mark;
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        half_mark = reqs_queued + n_reqs / 2;
        stop_mark = reqs_queued + n_reqs;
        while (reqs_queued < half_mark)
        begin
            if ($urandom_range(9) < 7)
                queue_name();
            else
                queue_noise($urandom_range(1, 4));
        end
        // The receiver stops for the LONG_HOLD hold-off, so the block backs up.
        if (long_hold)
            hold_toggle = ~hold_toggle;
        // The sender stops until the block has delivered everything.
        if (mid_pause)
            wait_drained();
        while (reqs_queued < stop_mark)
        begin
            if ($urandom_range(9) < 7)
                queue_name();
            else
                queue_noise($urandom_range(1, 4));
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial
    begin
        int spin;
        @(posedge rst_n);

        // Directed: extreme bytes, zero character, empty labels, bare finish.
        @(negedge clk);
        push_req(CMD_CHAR, 8'h00);
        push_req(CMD_CHAR, 8'hFF);
        push_req(CMD_CHAR, DOT_CHAR);
        push_req(CMD_CHAR, 8'h01);
        push_req(CMD_CHAR, DOT_CHAR);
        push_req(CMD_CHAR, DOT_CHAR);
        push_req(CMD_FINISH, 8'hFF);
        push_req(CMD_CHAR, DOT_CHAR);
        push_req(CMD_CHAR, 8'h80);
        push_req(CMD_FINISH, 8'h01);
        push_req(CMD_FINISH, 8'h7F);
        wait_drained();

        // Budget of one: a character overflows, then the rest of the name is discarded.
        write_budget(1);
        push_req(CMD_CHAR, 8'h61);
        push_req(CMD_CHAR, 8'h62);
        push_req(CMD_CHAR, DOT_CHAR);
        push_req(CMD_FINISH, 8'h01);
        push_req(CMD_FINISH, 8'h01);
        wait_drained();

        // Budget runs out on the terminator, then on a separator.
        write_budget(3);
        push_req(CMD_CHAR, 8'h61);
        push_req(CMD_CHAR, 8'h62);
        push_req(CMD_FINISH, 8'h01);
        write_budget(2);
        push_req(CMD_CHAR, 8'h61);
        push_req(CMD_CHAR, DOT_CHAR);
        push_req(CMD_FINISH, 8'h01);
        wait_drained();

        // Zero budget: even an empty name overflows.
        write_budget(0);
        push_req(CMD_FINISH, 8'h01);
        push_req(CMD_CHAR, 8'h61);
        push_req(CMD_FINISH, 8'h01);
        wait_drained();

        // Largest budget: a full-length label, then one character too many.
        write_budget(65535);
        @(negedge clk);
        for (int i = 0; i <= MAX_LABEL; i++)
            push_req(CMD_CHAR, label_char());
        push_req(CMD_FINISH, 8'h01);
        wait_drained();

        // Random phases over several budgets and idling patterns.
        random_phase(0, 0, 6, 1'b0, 1'b0);
        write_budget($urandom_range(8, 40));
        random_phase(56, 0, 6, 1'b0, 1'b1);
        write_budget(512);
        random_phase(0, 56, 6, 1'b1, 1'b0);
        write_budget(20);
        random_phase(7, 7, 6, 1'b0, 1'b0);

        // Give any stray result time to appear.
        spin = 0;
        while (wire_bytes_due.size() != 0 && spin < 200000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (30) @(negedge clk);
        if (wire_bytes_due.size() != 0)
        begin
            $error("%0d expected results never arrived", wire_bytes_due.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("** dns_name_label_encoder: PASSED **");
        else
            $display("** dns_name_label_encoder: FAILED **");
        $finish;
    end

endmodule
